FILE: hw/rtl/fdr_pkg.sv
`default_nettype none

package fdr_pkg;

  // Display geometry
  localparam int Width  = 56;
  localparam int Height = 16;

  // Field widths of the item ports
  localparam int ColFieldW = 6;
  localparam int RowFieldW = 4;
  localparam int ColSelW   = 64;
  localparam int RowSelW   = 32;

  // Storage and pointer widths
  localparam int AddrW   = (Width > 1) ? $clog2(Width) : 1;
  localparam int PtrColW = $clog2(Width + 1);
  localparam int RowW    = (Height > 1) ? $clog2(Height) : 1;
  localparam int WordW   = 2 * Height;

  // Driver remapping
  localparam int RemapCol     = 30;
  localparam int RemapShift   = 2;
  localparam int RowBankCol   = 32;
  localparam int RowBankShift = 16;

  localparam int QueueDepth = 2;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_SCAN  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SCAN,
    OP_CLEAR
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WR_WB,
    ST_SCAN_CHK
  } back_state_e;

  typedef struct packed {
    logic [1:0]           mode;
    logic [ColFieldW-1:0] col;
    logic [RowFieldW-1:0] row;
    logic                 pixel_on;
  } in_item_t;

  typedef struct packed {
    logic               dot_valid;
    logic [ColSelW-1:0] col_select;
    logic [RowSelW-1:0] row_select;
    logic               flip_set;
    logic               done_res;
  } out_item_t;

  typedef struct packed {
    op_e                  op;
    logic [ColFieldW-1:0] col;
    logic [RowFieldW-1:0] row;
    logic                 pixel_on;
  } cmd_t;

  // Queue to back end: head entry and its presence
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  function automatic out_item_t make_dot(logic [ColFieldW-1:0] x,
                                         logic [RowFieldW-1:0] y,
                                         logic dir);
    out_item_t            res;
    logic [ColFieldW-1:0] c;
    logic [4:0]           r;
    c = (x >= ColFieldW'(RemapCol)) ? x + ColFieldW'(RemapShift) : x;
    r = (c >= ColFieldW'(RowBankCol)) ? 5'(y) + 5'(RowBankShift) : 5'(y);
    res.dot_valid  = 1'b1;
    res.col_select = ColSelW'(1) << c;
    res.row_select = RowSelW'(1) << r;
    res.flip_set   = dir;
    res.done_res   = 1'b0;
    return res;
  endfunction

  function automatic out_item_t make_done();
    out_item_t res;
    res.dot_valid  = 1'b0;
    res.col_select = '0;
    res.row_select = '0;
    res.flip_set   = 1'b0;
    res.done_res   = 1'b1;
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fdr_front.sv
`default_nettype none

module fdr_front (
  input  wire logic              start,
  input  wire logic              busy,
  input  wire fdr_pkg::in_item_t item_i,
  output logic                   push_o,
  output fdr_pkg::cmd_t          cmd_o
);

  logic keep;
  logic in_range;

  assign in_range = (item_i.col < fdr_pkg::ColFieldW'(fdr_pkg::Width)) &&
                    ({1'b0, item_i.row} < 5'(fdr_pkg::Height));

  // Drop unused modes and writes that land outside the panel
  always_comb begin
    keep           = 1'b0;
    cmd_o.op       = fdr_pkg::OP_SCAN;
    cmd_o.col      = item_i.col;
    cmd_o.row      = item_i.row;
    cmd_o.pixel_on = item_i.pixel_on;
    case (fdr_pkg::mode_e'(item_i.mode))
      fdr_pkg::MODE_WRITE: begin
        keep     = in_range;
        cmd_o.op = fdr_pkg::OP_WRITE;
      end
      fdr_pkg::MODE_SCAN: begin
        keep     = 1'b1;
        cmd_o.op = fdr_pkg::OP_SCAN;
      end
      fdr_pkg::MODE_CLEAR: begin
        keep     = 1'b1;
        cmd_o.op = fdr_pkg::OP_CLEAR;
      end
      default: begin
        keep     = 1'b0;
        cmd_o.op = fdr_pkg::OP_SCAN;
      end
    endcase
  end

  assign push_o = start && !busy && keep;

endmodule

`default_nettype wire

FILE: hw/rtl/fdr_queue.sv
`default_nettype none

module fdr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire fdr_pkg::cmd_t  cmd_i,
  output logic                full_o,
  output fdr_pkg::cmd_slot_t  head_o,
  input  wire logic           pop_i
);

  fdr_pkg::cmd_t                    slot_q [fdr_pkg::QueueDepth];
  logic [fdr_pkg::QueuePtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [fdr_pkg::QueuePtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [fdr_pkg::QueueCntW-1:0]    cnt_q, cnt_d;
  logic                             do_pop;

  assign full_o = (cnt_q == fdr_pkg::QueueCntW'(fdr_pkg::QueueDepth));
  assign head_o = {(cnt_q != '0), slot_q[rd_ptr_q]};
  assign do_pop = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == fdr_pkg::QueuePtrW'(fdr_pkg::QueueDepth - 1)) ? '0
                                                                           : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == fdr_pkg::QueuePtrW'(fdr_pkg::QueueDepth - 1)) ? '0
                                                                           : rd_ptr_q + 1'b1;
    end
    case ({push_i, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fdr_back.sv
`default_nettype none

module fdr_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fdr_pkg::cmd_slot_t head_i,
  output logic                    pop_o,
  output logic                    res_valid_o,
  output fdr_pkg::out_item_t      res_o
);

  localparam int H = fdr_pkg::Height;

  fdr_pkg::back_state_e state_q, state_d;

  // Column store: wanted bits on top, shown bits below
  logic [fdr_pkg::WordW-1:0]   mem_q [fdr_pkg::Width];
  logic [fdr_pkg::Width-1:0]   col_valid_q, col_valid_d;
  logic [fdr_pkg::WordW-1:0]   rdata_q;
  logic                        rvalid_q;

  logic                        rd_en;
  logic [fdr_pkg::AddrW-1:0]   rd_addr;
  logic                        wr_en;
  logic [fdr_pkg::AddrW-1:0]   wr_addr;
  logic [fdr_pkg::WordW-1:0]   wr_data;
  logic                        valid_clr;

  fdr_pkg::cmd_t               cur_q, cur_d;
  logic [fdr_pkg::PtrColW-1:0] ptr_col_q, ptr_col_d;
  logic [fdr_pkg::RowW-1:0]    ptr_row_q, ptr_row_d;
  logic                        sweep_q, sweep_d;
  logic                        res_valid_q, res_valid_d;
  fdr_pkg::out_item_t          res_q, res_d;

  logic [fdr_pkg::WordW-1:0]   word;
  logic [H-1:0]                wanted;
  logic [H-1:0]                shown;
  logic [H-1:0]                diff;
  logic [H-1:0]                row_mask;
  logic [H-1:0]                hit_mask;
  logic [H-1:0]                wr_mask;
  logic [fdr_pkg::RowW-1:0]    hit_row;
  logic                        found;
  logic [fdr_pkg::PtrColW-1:0] next_col;
  logic                        ptr_in_panel;
  logic                        ptr_last_row;
  logic                        hit_last_row;

  // Never-written columns read as zero
  assign word   = rvalid_q ? rdata_q : '0;
  assign wanted = word[fdr_pkg::WordW-1:H];
  assign shown  = word[H-1:0];

  always_comb begin
    for (int i = 0; i < H; i++) begin
      row_mask[i] = (fdr_pkg::RowW'(i) >= ptr_row_q);
    end
  end

  assign diff = (wanted ^ shown) & row_mask;
  assign found = |diff;

  always_comb begin
    hit_row = '0;
    for (int i = H - 1; i >= 0; i--) begin
      if (diff[i]) begin
        hit_row = fdr_pkg::RowW'(i);
      end
    end
  end

  assign hit_mask     = H'(1) << hit_row;
  assign wr_mask      = H'(1) << cur_q.row[fdr_pkg::RowW-1:0];
  assign next_col     = ptr_col_q + 1'b1;
  assign ptr_in_panel = (ptr_col_q < fdr_pkg::PtrColW'(fdr_pkg::Width));
  assign ptr_last_row = (ptr_row_q == fdr_pkg::RowW'(H - 1));
  assign hit_last_row = (hit_row == fdr_pkg::RowW'(H - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fdr_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          case (head_i.cmd.op)
            fdr_pkg::OP_WRITE: state_d = fdr_pkg::ST_WR_WB;
            fdr_pkg::OP_SCAN: begin
              if (!sweep_q && ptr_in_panel) begin
                state_d = fdr_pkg::ST_SCAN_CHK;
              end
            end
            default: state_d = fdr_pkg::ST_IDLE;
          endcase
        end
      end
      fdr_pkg::ST_WR_WB: state_d = fdr_pkg::ST_IDLE;
      fdr_pkg::ST_SCAN_CHK: begin
        if (found || !(next_col < fdr_pkg::PtrColW'(fdr_pkg::Width))) begin
          state_d = fdr_pkg::ST_IDLE;
        end
      end
      default: state_d = fdr_pkg::ST_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = ptr_col_q[fdr_pkg::AddrW-1:0];
    wr_en       = 1'b0;
    wr_addr     = cur_q.col[fdr_pkg::AddrW-1:0];
    wr_data     = word;
    valid_clr   = 1'b0;
    cur_d       = cur_q;
    ptr_col_d   = ptr_col_q;
    ptr_row_d   = ptr_row_q;
    sweep_d     = sweep_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    case (state_q)
      fdr_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          cur_d = head_i.cmd;
          case (head_i.cmd.op)
            fdr_pkg::OP_WRITE: begin
              rd_en   = 1'b1;
              rd_addr = head_i.cmd.col[fdr_pkg::AddrW-1:0];
            end
            fdr_pkg::OP_CLEAR: begin
              valid_clr = 1'b1;
              ptr_col_d = '0;
              ptr_row_d = '0;
              sweep_d   = 1'b1;
            end
            fdr_pkg::OP_SCAN: begin
              if (sweep_q) begin
                res_valid_d = 1'b1;
                if (ptr_in_panel) begin
                  res_d = fdr_pkg::make_dot(fdr_pkg::ColFieldW'(ptr_col_q),
                                            fdr_pkg::RowFieldW'(ptr_row_q), 1'b0);
                  if (ptr_last_row) begin
                    ptr_col_d = next_col;
                    ptr_row_d = '0;
                  end else begin
                    ptr_row_d = ptr_row_q + 1'b1;
                  end
                end else begin
                  res_d     = fdr_pkg::make_done();
                  sweep_d   = 1'b0;
                  ptr_col_d = '0;
                  ptr_row_d = '0;
                end
              end else if (ptr_in_panel) begin
                rd_en = 1'b1;
              end else begin
                res_valid_d = 1'b1;
                res_d       = fdr_pkg::make_done();
                ptr_col_d   = '0;
                ptr_row_d   = '0;
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      fdr_pkg::ST_WR_WB: begin
        wr_en = 1'b1;
        if (cur_q.pixel_on) begin
          wr_data = {wanted | wr_mask, shown};
        end else begin
          wr_data = {wanted & ~wr_mask, shown};
        end
      end
      fdr_pkg::ST_SCAN_CHK: begin
        if (found) begin
          // Flip the dot and record it as shown
          wr_en       = 1'b1;
          wr_addr     = ptr_col_q[fdr_pkg::AddrW-1:0];
          wr_data     = {wanted, shown ^ hit_mask};
          res_valid_d = 1'b1;
          res_d       = fdr_pkg::make_dot(fdr_pkg::ColFieldW'(ptr_col_q),
                                          fdr_pkg::RowFieldW'(hit_row),
                                          |(wanted & hit_mask));
          if (hit_last_row) begin
            ptr_col_d = next_col;
            ptr_row_d = '0;
          end else begin
            ptr_row_d = hit_row + 1'b1;
          end
        end else if (next_col < fdr_pkg::PtrColW'(fdr_pkg::Width)) begin
          // Advance to the next column word
          rd_en     = 1'b1;
          rd_addr   = next_col[fdr_pkg::AddrW-1:0];
          ptr_col_d = next_col;
          ptr_row_d = '0;
        end else begin
          res_valid_d = 1'b1;
          res_d       = fdr_pkg::make_done();
          ptr_col_d   = '0;
          ptr_row_d   = '0;
        end
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    col_valid_d = col_valid_q;
    if (valid_clr) begin
      col_valid_d = '0;
    end else if (wr_en) begin
      col_valid_d[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdr_pkg::ST_IDLE;
      col_valid_q <= '0;
      ptr_col_q   <= '0;
      ptr_row_q   <= '0;
      sweep_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_valid_q <= col_valid_d;
      ptr_col_q   <= ptr_col_d;
      ptr_row_q   <= ptr_row_d;
      sweep_q     <= sweep_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q  <= mem_q[rd_addr];
      rvalid_q <= col_valid_q[rd_addr];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/flip_disc_diff_refresh.sv
// Channel   Ports                        Transfer
// --------  ---------------------------  -----------------------------------
// command   start, busy, item_i          start high and busy low at the edge
// result    res_valid_o, res_o           res_valid_o high, one cycle, no stall
//
// Commands go into a two-entry queue; busy is high only while it is full.
// Back end, one command at a time: a write reads its column word, then writes
// it back; clear and sweep step act in idle; a scan reads column words in turn
// through the single read port of the column store. Results are registered.
// Reset empties the queue, zeroes the pointer and marks all columns unwritten.
// The receiver cannot stall; every result is a transfer in its strobe cycle.
`default_nettype none

module flip_disc_diff_refresh (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire fdr_pkg::in_item_t item_i,
  output logic                   res_valid_o,
  output fdr_pkg::out_item_t     res_o
);

  logic               push;
  logic               pop;
  fdr_pkg::cmd_t      cmd;
  fdr_pkg::cmd_slot_t head;

  fdr_front u_front (
    .start  (start),
    .busy   (busy),
    .item_i (item_i),
    .push_o (push),
    .cmd_o  (cmd)
  );

  fdr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .full_o (busy),
    .head_o (head),
    .pop_i  (pop)
  );

  fdr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
